>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the binning/white-balance RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBWB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BBWB_NEVER(lbl, clk, rstn, cond, msg) \
  `BBWB_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define BBWB_ASSERT(lbl, clk, rstn, prop, msg)
`define BBWB_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/bbwb_pkg.sv
// ----------------------------------------------------------------------------
// bbwb_pkg
// Shared widths, register codes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package bbwb_pkg;

  localparam int PIX_W      = 8;
  localparam int LW_W       = 12;
  localparam int BR_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [LW_W-1:0] LW_RESET = 12'd1296;
  localparam logic [BR_W-1:0] BR_RESET = 10'd256;

  localparam logic [3:0] WB_RED_GAIN  = 4'd13;
  localparam logic [3:0] WB_BLUE_GAIN = 4'd10;
  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;

  typedef enum logic {
    ROW_EVEN,
    ROW_ODD
  } row_e;

  typedef struct packed {
    logic we_lo;
    logic we_hi;
    logic rd_en;
    logic hold_blue;
    logic issue;
    logic row_last;
    logic frame_start;
  } cmd_t;

  typedef struct packed {
    logic s1_free;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/bbwb_if.sv
// ----------------------------------------------------------------------------
// bbwb_if
// Valid/ready channel interfaces: Bayer pixel input, RGB output, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbwb_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bbwb_pkg::PIX_W-1:0] pixel;
  logic                       start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface bbwb_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [bbwb_pkg::PIX_W-1:0] red;
  logic [bbwb_pkg::PIX_W-1:0] green;
  logic [bbwb_pkg::PIX_W-1:0] blue;
  logic                       row_last;
  logic                       frame_start;

  modport source (output valid, output red, output green, output blue,
                  output row_last, output frame_start, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input row_last, input frame_start, output ready);
endinterface

interface bbwb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bbwb_pkg::CFG_IDX_W-1:0]  index;
  logic [bbwb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bbwb_ctrl.sv
// ----------------------------------------------------------------------------
// bbwb_ctrl
// Row state machine and column counter; issues store and output commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbwb_ctrl #(
  parameter  int MAX_WIDTH = bbwb_pkg::DEF_MAX_WIDTH,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int AW        = $clog2(MAX_WIDTH / 2)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_sof_i,
  output logic                      in_ready_o,
  input  logic [bbwb_pkg::LW_W-1:0] line_width_i,
  input  bbwb_pkg::stat_t           stat_i,
  output bbwb_pkg::cmd_t            cmd_o,
  output logic [AW-1:0]             addr_o
);

  localparam int EW = (CW + 1 > bbwb_pkg::LW_W) ? CW + 1 : bbwb_pkg::LW_W;

  bbwb_pkg::row_e row_q, row_d, row_eff;
  logic [CW-1:0]  col_q, col_d, col_eff;
  logic           fp_q, fp_d, fp_eff;

  logic           accept;
  logic [EW-1:0]  lw_ext;
  logic [EW-1:0]  wid_clamp;
  logic [CW:0]    wid;
  logic [CW:0]    col_inc;
  logic [CW-1:0]  pairs;
  logic [CW-1:0]  pair;
  logic           in_range;
  logic           wrap;
  logic           last_pair;

  assign in_ready_o = stat_i.s1_free;
  assign accept     = in_valid_i & in_ready_o;

  assign row_eff = in_sof_i ? bbwb_pkg::ROW_EVEN : row_q;
  assign col_eff = in_sof_i ? '0 : col_q;
  assign fp_eff  = in_sof_i | fp_q;

  always_comb begin
    lw_ext    = EW'(line_width_i);
    wid_clamp = lw_ext;
    if (lw_ext > EW'(MAX_WIDTH)) begin
      wid_clamp = EW'(MAX_WIDTH);
    end
    if (wid_clamp < EW'(2)) begin
      wid_clamp = EW'(2);
    end
    wid = wid_clamp[CW:0];
  end

  assign col_inc   = {1'b0, col_eff} + (CW + 1)'(1);
  assign wrap      = col_inc >= wid;
  assign pairs     = wid[CW:1];
  assign pair      = {1'b0, col_eff[CW-1:1]};
  assign in_range  = {1'b0, col_eff} < {wid[CW:1], 1'b0};
  assign last_pair = pair == (pairs - CW'(1));
  assign addr_o    = col_eff[AW:1];

  // next state
  always_comb begin
    row_d = row_q;
    if (accept && wrap) begin
      unique case (row_eff)
        bbwb_pkg::ROW_EVEN: row_d = bbwb_pkg::ROW_ODD;
        bbwb_pkg::ROW_ODD:  row_d = bbwb_pkg::ROW_EVEN;
        default:            row_d = bbwb_pkg::ROW_EVEN;
      endcase
    end else if (accept) begin
      row_d = row_eff;
    end
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    if (accept && in_range) begin
      unique case (row_eff)
        bbwb_pkg::ROW_EVEN: begin
          cmd_o.we_lo = ~col_eff[0];
          cmd_o.we_hi = col_eff[0];
        end
        bbwb_pkg::ROW_ODD: begin
          cmd_o.rd_en       = ~col_eff[0];
          cmd_o.hold_blue   = ~col_eff[0];
          cmd_o.issue       = col_eff[0];
          cmd_o.row_last    = col_eff[0] & last_pair;
          cmd_o.frame_start = col_eff[0] & fp_eff;
        end
        default: cmd_o = '0;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    fp_d  = fp_q;
    if (accept) begin
      col_d = wrap ? '0 : col_inc[CW-1:0];
      fp_d  = cmd_o.issue ? 1'b0 : fp_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= bbwb_pkg::ROW_EVEN;
      col_q <= '0;
      fp_q  <= 1'b1;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      fp_q  <= fp_d;
    end
  end

  `BBWB_ASSERT(a_issue_clears_first, clk_i, rst_ni, cmd_o.issue |=> !fp_q, "first flag kept after output")
  `BBWB_ASSERT(a_sof_restarts_row, clk_i, rst_ni, (accept && in_sof_i) |=> (col_q == CW'(1) && row_q == bbwb_pkg::ROW_EVEN), "start of frame did not restart row")
  `BBWB_ASSERT(a_col_bounded, clk_i, rst_ni, {1'b0, col_q} < (CW + 1)'(MAX_WIDTH), "column count beyond maximum width")

endmodule

`default_nettype wire

>>> sv/bbwb_dpath.sv
// ----------------------------------------------------------------------------
// bbwb_dpath
// Even-row line store, white balance, brightness multiply and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbwb_dpath #(
  parameter  int MAX_WIDTH = bbwb_pkg::DEF_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH / 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bbwb_pkg::cmd_t             cmd_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [bbwb_pkg::PIX_W-1:0] pixel_i,
  input  logic [bbwb_pkg::BR_W-1:0]  brightness_i,
  output bbwb_pkg::stat_t            stat_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bbwb_pkg::PIX_W-1:0] red_o,
  output logic [bbwb_pkg::PIX_W-1:0] green_o,
  output logic [bbwb_pkg::PIX_W-1:0] blue_o,
  output logic                       row_last_o,
  output logic                       frame_start_o
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int PW          = bbwb_pkg::PIX_W;
  localparam int MW          = PW + 1 + bbwb_pkg::BR_W;

  function automatic logic [PW-1:0] sat_scale(input logic [MW-1:0] p);
    logic [PW-1:0] r;
    r = (|p[MW-1:2*PW]) ? bbwb_pkg::SAT_MAX : p[2*PW-1:PW];
    return r;
  endfunction

  logic [PW-1:0] store_lo [STORE_DEPTH];
  logic [PW-1:0] store_hi [STORE_DEPTH];
  logic [PW-1:0] rd_lo_q, rd_hi_q;
  logic [PW-1:0] blue_q;

  logic [11:0]   red_mul, blue_mul;
  logic [PW:0]   green_sum;

  logic          s1_valid_q, s1_valid_d;
  logic [PW:0]   s1_red_q, s1_blue_q;
  logic [PW-1:0] s1_green_q;
  logic          s1_le_q, s1_fs_q;
  logic          s1_adv;

  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_red_q, out_green_q, out_blue_q;
  logic          out_le_q, out_fs_q;

  logic [MW-1:0] red_p, green_p, blue_p;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we_lo) begin
      store_lo[addr_i] <= pixel_i;
    end
    if (cmd_i.we_hi) begin
      store_hi[addr_i] <= pixel_i;
    end
    if (cmd_i.rd_en) begin
      rd_lo_q <= store_lo[addr_i];
      rd_hi_q <= store_hi[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blue_q <= '0;
    end else if (cmd_i.hold_blue) begin
      blue_q <= pixel_i;
    end
  end

  assign red_mul   = 12'(rd_hi_q) * 12'(bbwb_pkg::WB_RED_GAIN);
  assign blue_mul  = 12'(blue_q) * 12'(bbwb_pkg::WB_BLUE_GAIN);
  assign green_sum = {1'b0, rd_lo_q} + {1'b0, pixel_i};

  assign s1_adv         = s1_valid_q & (~out_valid_q | out_ready_i);
  assign stat_o.s1_free = ~s1_valid_q | ~out_valid_q | out_ready_i;

  assign s1_valid_d  = cmd_i.issue | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_red_q   <= red_mul[11:3];
      s1_blue_q  <= blue_mul[11:3];
      s1_green_q <= green_sum[PW:1];
      s1_le_q    <= cmd_i.row_last;
      s1_fs_q    <= cmd_i.frame_start;
    end
  end

  assign red_p   = MW'(s1_red_q) * MW'(brightness_i);
  assign green_p = MW'(s1_green_q) * MW'(brightness_i);
  assign blue_p  = MW'(s1_blue_q) * MW'(brightness_i);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_red_q   <= sat_scale(red_p);
      out_green_q <= sat_scale(green_p);
      out_blue_q  <= sat_scale(blue_p);
      out_le_q    <= s1_le_q;
      out_fs_q    <= s1_fs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = out_red_q;
  assign green_o       = out_green_q;
  assign blue_o        = out_blue_q;
  assign row_last_o    = out_le_q;
  assign frame_start_o = out_fs_q;

  `BBWB_NEVER(a_store_port_conflict, clk_i, rst_ni, cmd_i.rd_en && (cmd_i.we_lo || cmd_i.we_hi), "line store read and written together")
  `BBWB_ASSERT(a_issue_has_room, clk_i, rst_ni, cmd_i.issue |-> (!s1_valid_q || s1_adv), "issue into occupied stage")
  `BBWB_ASSERT(a_stage_drains, clk_i, rst_ni, (s1_valid_q && !out_valid_q) |=> out_valid_q, "stage did not move into empty output")

endmodule

`default_nettype wire

>>> sv/bayer_bin_white_balance.sv
// ----------------------------------------------------------------------------
// bayer_bin_white_balance
// GRBG 2x2 binning to half-resolution RGB with white balance and brightness.
// ----------------------------------------------------------------------------
//  port    | dir | transaction
//  pix_i   | in  | one Bayer sample + start_of_frame, raster order
//  rgb_o   | out | one RGB pixel per 2x2 cell + row_last, frame_start
//  cfg_i   | in  | register write: 0 line_width, 1 brightness
//
//  One pixel accepted per cycle while pix_i.ready is high; the lower right
//  green of a cell issues it through the white-balance and multiply registers.
//  pix_i.ready drops only when both pipeline registers hold results and
//  rgb_o is stalled. Reset clears control state at once; the line store needs
//  no clearing pass. cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_bin_white_balance #(
  parameter int MAX_WIDTH = bbwb_pkg::DEF_MAX_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bbwb_pix_if.sink          pix_i,
  bbwb_rgb_if.source        rgb_o,
  bbwb_cfg_if.sink          cfg_i
);

  localparam int AW = $clog2(MAX_WIDTH / 2);

  logic [bbwb_pkg::LW_W-1:0] lw_q;
  logic [bbwb_pkg::BR_W-1:0] br_q;
  bbwb_pkg::cmd_t            cmd;
  bbwb_pkg::stat_t           stat;
  logic [AW-1:0]             addr;
  logic                      in_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= bbwb_pkg::LW_RESET;
      br_q <= bbwb_pkg::BR_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bbwb_pkg::CFG_LINE_WIDTH: lw_q <= cfg_i.data;
        bbwb_pkg::CFG_BRIGHTNESS: br_q <= cfg_i.data[bbwb_pkg::BR_W-1:0];
        default: ;
      endcase
    end
  end

  bbwb_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pix_i.valid),
    .in_sof_i     (pix_i.start_of_frame),
    .in_ready_o   (in_ready),
    .line_width_i (lw_q),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .addr_o       (addr)
  );

  assign pix_i.ready = in_ready;

  bbwb_dpath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .pixel_i       (pix_i.pixel),
    .brightness_i  (br_q),
    .stat_o        (stat),
    .out_valid_o   (rgb_o.valid),
    .out_ready_i   (rgb_o.ready),
    .red_o         (rgb_o.red),
    .green_o       (rgb_o.green),
    .blue_o        (rgb_o.blue),
    .row_last_o    (rgb_o.row_last),
    .frame_start_o (rgb_o.frame_start)
  );

endmodule

`default_nettype wire
